// File: src/pfrf_pkg.sv
`default_nettype none

package pfrf_pkg;

    localparam int PAGE_ROWS = 8;
    localparam int ROW_MASK  = 7;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int PAGE_W    = 4;
    localparam int IDX_W     = 10;
    localparam int Q_DEPTH   = 2;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // one classified command, rectangle already clipped to the screen
    typedef struct packed {
        logic             is_read;
        logic             lit;
        logic [IDX_W-1:0] idx;
        logic [COL_W-1:0] x_lo;
        logic [COL_W-1:0] x_last;
        logic [ROW_W-1:0] y_lo;
        logic [ROW_W-1:0] y_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// File: src/page_framebuffer_rect_fill_top.sv
// channel   | handshake              | ports
// ----------+------------------------+-----------------------------------------------
// command   | start high, busy low   | i_action i_x_start i_y_start i_rect_width
//           |                        | i_rect_height i_pixel_value i_byte_index
// read data | o_read_valid, 1 cycle  | o_read_data
//
// fill visits the clipped rectangle page by page and column by column, one store byte
// per cycle through a pipelined read-modify-write on the frame store
// a read passes through S_READ and then S_RESP before its beat; a 2-deep command
// queue lets the front take beats while the back works, busy is high when the queue
// and the front stage are full; after reset a clear pass zeroes all SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8) bytes of the store, busy stays high through it
// the receiver cannot stall: each read beat is shown for one cycle
`default_nettype none

module page_framebuffer_rect_fill_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_action,
    input  wire logic signed [8:0] i_x_start,
    input  wire logic signed [8:0] i_y_start,
    input  wire logic [7:0]        i_rect_width,
    input  wire logic [7:0]        i_rect_height,
    input  wire logic              i_pixel_value,
    input  wire logic [9:0]        i_byte_index,
    output logic                   o_read_valid,
    output logic [7:0]             o_read_data
);
    import pfrf_pkg::*;

    logic    push;
    logic    pop;
    logic    clearing;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;

    pfrf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_pixel_value (i_pixel_value),
        .i_byte_index  (i_byte_index),
        .i_clearing    (clearing),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    pfrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    pfrf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data)
    );

endmodule

`default_nettype wire

// File: src/pfrf_front.sv
`default_nettype none

module pfrf_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic signed [8:0]  i_x_start,
    input  wire logic signed [8:0]  i_y_start,
    input  wire logic [7:0]         i_rect_width,
    input  wire logic [7:0]         i_rect_height,
    input  wire logic               i_pixel_value,
    input  wire logic [9:0]         i_byte_index,
    input  wire logic               i_clearing,
    input  wire pfrf_pkg::t_q_stat  i_q_stat,
    output logic                    o_push,
    output pfrf_pkg::t_cmd          o_cmd
);
    import pfrf_pkg::*;

    localparam logic signed [9:0] SW_S = 10'(SCREEN_WIDTH);
    localparam logic signed [9:0] SH_S = 10'(SCREEN_HEIGHT);

    logic              r_valid;
    logic              n_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic signed [9:0] xs, xe, ys, ye;
    logic signed [9:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [9:0] x_last, y_last;
    logic              accept;
    logic              keep;

    assign busy   = (r_valid & i_q_stat.full) | i_clearing;
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_q_stat.full;
    assign o_cmd  = r_cmd;

    // clip the rectangle to the screen
    always_comb begin
        xs     = 10'(i_x_start);
        ys     = 10'(i_y_start);
        xe     = xs + $signed({2'b00, i_rect_width});
        ye     = ys + $signed({2'b00, i_rect_height});
        x_lo   = (xs < 0) ? 10'sd0 : xs;
        y_lo   = (ys < 0) ? 10'sd0 : ys;
        x_hi   = (xe > SW_S) ? SW_S : xe;
        y_hi   = (ye > SH_S) ? SH_S : ye;
        x_last = x_hi - 10'sd1;
        y_last = y_hi - 10'sd1;
        keep   = (i_action == ACT_READ) || ((x_lo < x_hi) && (y_lo < y_hi));

        n_cmd.is_read = (i_action == ACT_READ);
        n_cmd.lit     = i_pixel_value;
        n_cmd.idx     = i_byte_index;
        n_cmd.x_lo    = x_lo[COL_W-1:0];
        n_cmd.x_last  = x_last[COL_W-1:0];
        n_cmd.y_lo    = y_lo[ROW_W-1:0];
        n_cmd.y_last  = y_last[ROW_W-1:0];

        n_valid = (accept & keep) | (r_valid & ~o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept & keep) begin
            r_cmd <= n_cmd;
        end
    end

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !accept) else $error("beat taken during clear pass");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_stat.full) |=> (r_valid && $stable(r_cmd)))
        else $error("stalled command lost");
    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_valid) else $error("push without command");

endmodule

`default_nettype wire

// File: src/pfrf_queue.sv
`default_nettype none

module pfrf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire pfrf_pkg::t_cmd     i_cmd,
    input  wire logic               i_pop,
    output pfrf_pkg::t_cmd          o_head,
    output pfrf_pkg::t_q_stat       o_stat
);
    import pfrf_pkg::*;

    t_cmd       r_mem [Q_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(Q_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: src/pfrf_back.sv
`default_nettype none

module pfrf_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pfrf_pkg::t_cmd     i_head,
    input  wire pfrf_pkg::t_q_stat  i_q_stat,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_read_valid,
    output logic [7:0]              o_read_data
);
    import pfrf_pkg::*;

    localparam int PAGES       = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [AW-1:0] PAGE_STEP = AW'(SCREEN_WIDTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_READ,
        S_RESP
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr;
    t_cmd              r_cmd;
    logic [COL_W-1:0]  r_col;
    logic [PAGE_W-1:0] r_page;
    logic [AW-1:0]     r_base;
    logic              r_wr_pend;
    logic [AW-1:0]     r_wr_addr;
    logic [7:0]        r_wr_mask;
    logic [7:0]        r_rdata;
    logic              r_out_stb;
    logic [7:0]        r_out_data;
    logic [7:0]        mem [STORE_BYTES];

    logic [AW-1:0]     rd_addr;
    logic [2:0]        lo_bit;
    logic [2:0]        hi_bit;
    logic [7:0]        mask;
    logic              we;
    logic [AW-1:0]     wa;
    logic [7:0]        wd;
    logic [PAGE_W-1:0] head_page;

    assign o_pop        = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_read_valid = r_out_stb;
    assign o_read_data  = r_out_data;
    assign head_page    = PAGE_W'(i_head.y_lo[ROW_W-1:3]);

    always_comb begin
        if (r_state == S_READ) begin
            rd_addr = AW'(r_cmd.idx);
        end else begin
            rd_addr = r_base + AW'(r_col);
        end
        // rows of the current page covered by the rectangle
        lo_bit = (r_page == PAGE_W'(r_cmd.y_lo[ROW_W-1:3])) ? r_cmd.y_lo[2:0] : 3'd0;
        hi_bit = (r_page == PAGE_W'(r_cmd.y_last[ROW_W-1:3])) ?
                 r_cmd.y_last[2:0] : 3'(ROW_MASK);
        mask   = (8'hFF << lo_bit) & (8'hFF >> (3'(ROW_MASK) - hi_bit));

        we = (r_state == S_CLEAR) || r_wr_pend;
        wa = (r_state == S_CLEAR) ? r_clr : r_wr_addr;
        if (r_state == S_CLEAR) begin
            wd = 8'h00;
        end else if (r_cmd.lit) begin
            wd = r_rdata | r_wr_mask;
        end else begin
            wd = r_rdata & ~r_wr_mask;
        end
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_wr_pend <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_wr_pend <= 1'b0;
            r_out_stb <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_cmd   <= i_head;
                        r_col   <= i_head.x_lo;
                        r_page  <= head_page;
                        r_base  <= AW'(int'(head_page) * SCREEN_WIDTH);
                        r_state <= i_head.is_read ? S_READ : S_FILL;
                    end
                end
                S_FILL: begin
                    // read this byte, write it back next cycle
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= rd_addr;
                    r_wr_mask <= mask;
                    if (r_col == r_cmd.x_last) begin
                        r_col <= r_cmd.x_lo;
                        if (r_page == PAGE_W'(r_cmd.y_last[ROW_W-1:3])) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_page <= r_page + PAGE_W'(1);
                            r_base <= r_base + PAGE_STEP;
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_out_stb  <= 1'b1;
                    r_out_data <= (int'(r_cmd.idx) >= STORE_BYTES) ? 8'h00 : r_rdata;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_stb_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_stb |-> $past(r_state == S_RESP)) else $error("stray read beat");
    a_wr_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(r_state == S_FILL)) else $error("stray write back");
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (r_state == S_FILL || r_state == S_IDLE))
        else $error("write back overlaps read");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop) else $error("pop during clear pass");

endmodule

`default_nettype wire
